@@ rtl/ssup_pkg.sv @@
// ----------------------------------------------------------------------------
// ssup_pkg
// Shared types and codes for the seal/outfeed job supervisor.
// ----------------------------------------------------------------------------
package ssup_pkg;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_UNLOAD = 3'd2,
    OP_STOP   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    PH_NONE     = 3'd0,
    PH_PRESEAL  = 3'd1,
    PH_INFLIGHT = 3'd2,
    PH_SEALDONE = 3'd3,
    PH_OUTFEED  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_LOAD   = 2'd1,
    MODE_UNLOAD = 2'd2
  } mode_e;

  typedef struct packed {
    logic [2:0] operation;
    logic       ofd_ready;
    logic       outfeed_cycle_active;
    logic       outfeed_divert_active;
    logic       outfeed_timed_run_active;
    logic [7:0] ofd_count;
    logic       outfeed_start_ok;
    logic       sealer_pulse_active;
    logic       sealer_wait_done;
    logic [7:0] sealer_seq;
    logic       sealer_start_ok;
  } event_t;

  typedef struct packed {
    logic       active_flag;
    logic       expects_seal;
    logic       activity_flag;
    logic       recovery_latch;
    logic       guard_pending;
    logic [7:0] ofd_count_base;
    logic [7:0] sealer_seq_base;
    mode_e      mode;
    phase_e     phase;
  } state_t;

  typedef struct packed {
    logic       accepted;
    logic       job_active;
    phase_e     phase_now;
    mode_e      job_mode;
    logic       recovery_required;
    logic       activity_seen;
    logic       seal_advanced;
    logic       start_outfeed_cmd;
    logic       start_seal_cmd;
    logic       abort_outfeed_cmd;
    logic       job_done;
  } result_t;

endpackage

@@ rtl/ssup_core.sv @@
// ----------------------------------------------------------------------------
// ssup_core
// Event decode, next job state and result for one supervisor event.
// ----------------------------------------------------------------------------
module ssup_core (
  input  ssup_pkg::state_t  cur_i,
  input  ssup_pkg::event_t  evt_i,
  output ssup_pkg::state_t  nxt_o,
  output ssup_pkg::result_t res_o
);

  function automatic ssup_pkg::phase_e resolve(ssup_pkg::state_t s, logic [7:0] sseq);
    ssup_pkg::phase_e p;
    if (!s.active_flag) p = ssup_pkg::PH_NONE;
    else if (!s.expects_seal) p = ssup_pkg::PH_OUTFEED;
    else if (s.phase == ssup_pkg::PH_PRESEAL) p = ssup_pkg::PH_PRESEAL;
    else if (sseq != s.sealer_seq_base) p = ssup_pkg::PH_SEALDONE;
    else p = ssup_pkg::PH_INFLIGHT;
    return p;
  endfunction

  ssup_pkg::op_e op;
  logic          go;
  logic          adv;
  logic          start_ok;
  logic          seal_busy;

  assign op        = ssup_pkg::op_e'(evt_i.operation);
  assign seal_busy = evt_i.sealer_pulse_active | evt_i.sealer_wait_done;

  always_comb begin
    nxt_o    = cur_i;
    res_o    = '0;
    go       = 1'b1;
    adv      = (evt_i.sealer_seq != cur_i.sealer_seq_base);
    start_ok = !cur_i.active_flag && !cur_i.recovery_latch &&
               !evt_i.outfeed_cycle_active && evt_i.outfeed_start_ok;
    unique case (op)
      ssup_pkg::OP_TICK: begin
        res_o.accepted = 1'b1;
        if (cur_i.active_flag) begin
          if (!evt_i.ofd_ready || evt_i.outfeed_cycle_active ||
              evt_i.outfeed_divert_active || evt_i.outfeed_timed_run_active ||
              evt_i.ofd_count != cur_i.ofd_count_base) begin
            nxt_o.activity_flag = 1'b1;
          end
          if (cur_i.expects_seal && cur_i.phase == ssup_pkg::PH_PRESEAL) begin
            if (cur_i.guard_pending) begin
              nxt_o.guard_pending = 1'b0;
              go = 1'b0;
            end else if (!evt_i.sealer_start_ok) begin
              res_o.abort_outfeed_cmd = evt_i.outfeed_cycle_active;
              nxt_o.active_flag = 1'b0;
              go = 1'b0;
            end else begin
              res_o.start_seal_cmd = 1'b1;
              nxt_o.phase = ssup_pkg::PH_INFLIGHT;
            end
          end
          if (go) begin
            if (cur_i.expects_seal && nxt_o.phase == ssup_pkg::PH_INFLIGHT && adv) begin
              nxt_o.phase = ssup_pkg::PH_SEALDONE;
            end
            if (evt_i.ofd_ready && (!cur_i.expects_seal || adv)) begin
              nxt_o.active_flag = 1'b0;
              nxt_o.phase = ssup_pkg::PH_NONE;
              res_o.job_done = 1'b1;
            end
          end
        end
      end
      ssup_pkg::OP_LOAD, ssup_pkg::OP_UNLOAD: begin
        if (start_ok && !(op == ssup_pkg::OP_LOAD && seal_busy)) begin
          res_o.accepted          = 1'b1;
          res_o.start_outfeed_cmd = 1'b1;
          nxt_o.active_flag       = 1'b1;
          nxt_o.mode              = (op == ssup_pkg::OP_LOAD) ? ssup_pkg::MODE_LOAD
                                                              : ssup_pkg::MODE_UNLOAD;
          nxt_o.expects_seal      = (op == ssup_pkg::OP_LOAD);
          nxt_o.phase             = (op == ssup_pkg::OP_LOAD) ? ssup_pkg::PH_PRESEAL
                                                              : ssup_pkg::PH_OUTFEED;
          nxt_o.guard_pending     = (op == ssup_pkg::OP_LOAD);
          nxt_o.activity_flag     = 1'b0;
          nxt_o.recovery_latch    = 1'b0;
          nxt_o.ofd_count_base    = evt_i.ofd_count;
          nxt_o.sealer_seq_base   = evt_i.sealer_seq;
        end
      end
      ssup_pkg::OP_STOP: begin
        if (cur_i.active_flag) begin
          res_o.accepted          = 1'b1;
          res_o.abort_outfeed_cmd = evt_i.outfeed_cycle_active;
          if (resolve(cur_i, evt_i.sealer_seq) == ssup_pkg::PH_INFLIGHT) begin
            nxt_o.recovery_latch = 1'b1;
          end
          nxt_o.active_flag = 1'b0;
          nxt_o.phase       = ssup_pkg::PH_NONE;
        end
      end
      ssup_pkg::OP_CLEAR: begin
        if (cur_i.active_flag) begin
          res_o.accepted = 1'b0;
        end else if (!cur_i.recovery_latch) begin
          res_o.accepted = 1'b1;
        end else if (!seal_busy) begin
          nxt_o.recovery_latch = 1'b0;
          res_o.accepted       = 1'b1;
        end
      end
      default: begin
      end
    endcase

    res_o.job_active        = nxt_o.active_flag;
    res_o.phase_now         = resolve(nxt_o, evt_i.sealer_seq);
    res_o.job_mode          = nxt_o.mode;
    res_o.recovery_required = nxt_o.recovery_latch;
    res_o.activity_seen     = nxt_o.activity_flag;
    res_o.seal_advanced     = nxt_o.expects_seal &&
                              (evt_i.sealer_seq != nxt_o.sealer_seq_base);
  end

endmodule

@@ rtl/seal_outfeed_job_supervisor_unit.sv @@
// Result path: the input register holds the event, then the result register holds the result.
// Throughput: one event per cycle unless a result is held; the job state register feeds back.
// The input stage accepts a new item while a result waits if the input register is
// empty, or if the result register frees up in that cycle.
// Reset: rst_ni asynchronous active low; clears job state and both valid flags.
// ----------------------------------------------------------------------------
// seal_outfeed_job_supervisor_unit
// Supervisor for one outfeed job with an optional seal step, one result per event.
// ----------------------------------------------------------------------------
module seal_outfeed_job_supervisor_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] operation_i,
  input  logic       ofd_ready_i,
  input  logic       outfeed_cycle_active_i,
  input  logic       outfeed_divert_active_i,
  input  logic       outfeed_timed_run_active_i,
  input  logic [7:0] ofd_count_i,
  input  logic       outfeed_start_ok_i,
  input  logic       sealer_pulse_active_i,
  input  logic       sealer_wait_done_i,
  input  logic [7:0] sealer_seq_i,
  input  logic       sealer_start_ok_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       accepted_o,
  output logic       job_active_o,
  output logic [2:0] phase_now_o,
  output logic [1:0] job_mode_o,
  output logic       recovery_required_o,
  output logic       activity_seen_o,
  output logic       seal_advanced_o,
  output logic       start_outfeed_cmd_o,
  output logic       start_seal_cmd_o,
  output logic       abort_outfeed_cmd_o,
  output logic       job_done_o
);

  logic              in_valid_q;
  ssup_pkg::event_t  evt_q;
  logic              out_valid_q;
  ssup_pkg::result_t res_q;
  ssup_pkg::result_t res_d;
  ssup_pkg::state_t  state_q;
  ssup_pkg::state_t  state_d;
  logic              advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      evt_q.operation                <= operation_i;
      evt_q.ofd_ready                <= ofd_ready_i;
      evt_q.outfeed_cycle_active     <= outfeed_cycle_active_i;
      evt_q.outfeed_divert_active    <= outfeed_divert_active_i;
      evt_q.outfeed_timed_run_active <= outfeed_timed_run_active_i;
      evt_q.ofd_count                <= ofd_count_i;
      evt_q.outfeed_start_ok         <= outfeed_start_ok_i;
      evt_q.sealer_pulse_active      <= sealer_pulse_active_i;
      evt_q.sealer_wait_done         <= sealer_wait_done_i;
      evt_q.sealer_seq               <= sealer_seq_i;
      evt_q.sealer_start_ok          <= sealer_start_ok_i;
    end
  end

  ssup_core u_core (
    .cur_i (state_q),
    .evt_i (evt_q),
    .nxt_o (state_d),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign accepted_o          = res_q.accepted;
  assign job_active_o        = res_q.job_active;
  assign phase_now_o         = res_q.phase_now;
  assign job_mode_o          = res_q.job_mode;
  assign recovery_required_o = res_q.recovery_required;
  assign activity_seen_o     = res_q.activity_seen;
  assign seal_advanced_o     = res_q.seal_advanced;
  assign start_outfeed_cmd_o = res_q.start_outfeed_cmd;
  assign start_seal_cmd_o    = res_q.start_seal_cmd;
  assign abort_outfeed_cmd_o = res_q.abort_outfeed_cmd;
  assign job_done_o          = res_q.job_done;

`ifndef SYNTHESIS
  a_done_ends_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && job_done_o |-> accepted_o && !job_active_o)
    else $error("job_done with job still active");

  a_phase_matches_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (job_active_o == (phase_now_o != ssup_pkg::PH_NONE)))
    else $error("phase and job_active disagree");

  a_start_opens_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_outfeed_cmd_o |-> accepted_o && job_active_o)
    else $error("outfeed start without an active job");

  a_latch_blocks_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && recovery_required_o |-> !job_active_o)
    else $error("job active while recovery latch set");

  a_held_event_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(evt_q))
    else $error("held event changed before processing");
`endif

endmodule
